// ----- rtl/cptd_pkg.sv -----
package cptd_pkg;

  localparam int MAX_CATEGORIES_DEF = 8;
  localparam int STORE_DEPTH_DEF    = 65536;
  localparam int ELEMENT_BITS_DEF   = 16;
  localparam int ACC_BITS_DEF       = 48;

  localparam int NDIMS         = 12;
  localparam int KW            = $clog2(NDIMS);
  localparam int DIM_BITS      = 8;
  localparam int CAT_BITS      = 4;
  localparam int IDX_BITS      = 6;
  localparam int SUM_BITS      = 48;
  localparam int REQ_BITS      = 2;
  localparam int ADDR_BITS     = 16;
  localparam int VAL_BITS      = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_SIGMA  = 2'd0,
    REQ_FILTER = 2'd1,
    REQ_RUN    = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_NUM_CAT = 3'd0,
    CFG_FIRST   = 3'd1,
    CFG_DEEPER  = 3'd2,
    CFG_KERNEL  = 3'd3,
    CFG_OUTSIZE = 3'd4,
    CFG_BCAST   = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_CHECK,
    ST_PAIR_INIT,
    ST_STREAM,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic mul_en;
    logic acc_en;
  } mac_ctl_t;

  // Broadcast mask bit that governs each dimension.
  function automatic logic [2:0] dim_group(input logic [KW-1:0] k);
    logic [2:0] g;
    case (k)
      4'd0:  g = 3'd0;
      4'd1:  g = 3'd1;
      4'd2:  g = 3'd2;
      4'd3:  g = 3'd2;
      4'd4:  g = 3'd3;
      4'd5:  g = 3'd4;
      4'd6:  g = 3'd4;
      4'd7:  g = 3'd5;
      4'd8:  g = 3'd6;
      4'd9:  g = 3'd6;
      default: g = 3'd7;
    endcase
    return g;
  endfunction

  function automatic logic [DIM_BITS-1:0] dim_sel(input logic [KW-1:0] k,
                                                  input logic [15:0] fcc,
                                                  input logic [15:0] dcc,
                                                  input logic [23:0] ks,
                                                  input logic [7:0]  os);
    logic [DIM_BITS-1:0] d;
    case (k)
      4'd0:  d = fcc[7:0];
      4'd1:  d = fcc[15:8];
      4'd2:  d = ks[7:0];
      4'd3:  d = ks[7:0];
      4'd4:  d = dcc[7:0];
      4'd5:  d = ks[15:8];
      4'd6:  d = ks[15:8];
      4'd7:  d = dcc[15:8];
      4'd8:  d = ks[23:16];
      4'd9:  d = ks[23:16];
      default: d = os;
    endcase
    return d;
  endfunction

endpackage

// ----- rtl/cptd_store.sv -----
module cptd_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16,
  parameter int EB    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EB-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [EB-1:0] rdata
);

  logic [EB-1:0] mem [DEPTH];
  logic [EB-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/cptd_mac.sv -----
module cptd_mac #(
  parameter int EB = 16,
  parameter int AB = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cptd_pkg::mac_ctl_t       ctl,
  input  logic signed [EB-1:0]     a,
  input  logic signed [EB-1:0]     b,
  output logic signed [AB-1:0]     acc
);
  import cptd_pkg::*;

  localparam int PB = 2 * EB;
  localparam int SW = ((AB > PB) ? AB : PB) + 1;
  localparam logic signed [SW-1:0] ACC_HI = {{(SW-AB+1){1'b0}}, {(AB-1){1'b1}}};
  localparam logic signed [SW-1:0] ACC_LO = ~ACC_HI;

  logic signed [PB-1:0] prod_r;
  logic signed [AB-1:0] acc_r;
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] sat;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= a * b;
    end
  end

  // saturate to the accumulator range on every add
  always_comb begin
    sum = SW'(acc_r) + SW'(prod_r);
    if (sum > ACC_HI) begin
      sat = ACC_HI;
    end else if (sum < ACC_LO) begin
      sat = ACC_LO;
    end else begin
      sat = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= sat[AB-1:0];
    end
  end

  assign acc = acc_r;

endmodule

// ----- rtl/category_pair_tensor_dot.sv -----
// Category pair tensor contraction. Load words (req_type 0/1) write one Q4.12 element
// into the sigma or filter store. A run word first sizes the tensors (one dimension per
// cycle, innermost first) and then checks them; if either tensor exceeds the store depth,
// a single error word comes out. Otherwise the block walks every category pair, i outer
// and j inner, streaming one sigma and one filter element per cycle through a single
// multiply-accumulate unit. Each pair runs through clear, inner reads, read and multiply
// pipeline drain, and result. Broadcast sigma groups are walked with stride zero by a
// counter chain that keeps a running offset per level. The input stalls for the whole
// run; a finished result sits in an output register, so load words are taken while it
// waits.
module category_pair_tensor_dot #(
  parameter int MAX_CATEGORIES = cptd_pkg::MAX_CATEGORIES_DEF,
  parameter int STORE_DEPTH    = cptd_pkg::STORE_DEPTH_DEF,
  parameter int ELEMENT_BITS   = cptd_pkg::ELEMENT_BITS_DEF,
  parameter int ACC_BITS       = cptd_pkg::ACC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [cptd_pkg::REQ_BITS-1:0]         in_req_type,
  input  logic [cptd_pkg::ADDR_BITS-1:0]        in_addr,
  input  logic signed [cptd_pkg::VAL_BITS-1:0]  in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [cptd_pkg::IDX_BITS-1:0]         out_pair_index,
  output logic signed [cptd_pkg::SUM_BITS-1:0]  out_dot_sum,
  output logic                                  out_last,
  output logic                                  out_size_error,
  input  logic                                  cfg_we,
  input  logic [cptd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [cptd_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
  import cptd_pkg::*;

  localparam int AW  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int SZW = $clog2(STORE_DEPTH + 2);
  localparam int PW  = SZW + DIM_BITS;
  localparam int CW  = $clog2(MAX_CATEGORIES + 1);

  // configuration registers
  logic [CAT_BITS-1:0] nc_r;
  logic [15:0]         fcc_r;
  logic [15:0]         dcc_r;
  logic [23:0]         ks_r;
  logic [7:0]          os_r;
  logic [7:0]          bm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r  <= CAT_BITS'(1);
      fcc_r <= 16'd257;
      dcc_r <= 16'd257;
      ks_r  <= 24'd65793;
      os_r  <= 8'd1;
      bm_r  <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NUM_CAT: nc_r  <= cfg_wdata[CAT_BITS-1:0];
        CFG_FIRST:   fcc_r <= cfg_wdata[15:0];
        CFG_DEEPER:  dcc_r <= cfg_wdata[15:0];
        CFG_KERNEL:  ks_r  <= cfg_wdata[23:0];
        CFG_OUTSIZE: os_r  <= cfg_wdata[7:0];
        CFG_BCAST:   bm_r  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_t              state_r, state_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic [SZW-1:0]      icap_r, icap_nxt;   // filter elements per category
  logic [SZW-1:0]      sin_r, sin_nxt;     // sigma elements per category
  logic [SZW-1:0]      sstride_r [NDIMS];
  logic [DIM_BITS-1:0] cnt_r [NDIMS];
  logic [DIM_BITS-1:0] cnt_nxt [NDIMS];
  logic [SZW-1:0]      off_r [NDIMS];
  logic [SZW-1:0]      off_nxt [NDIMS];
  logic [SZW-1:0]      t_r, t_nxt;
  logic [SZW-1:0]      sbase_r, sbase_nxt;
  logic [SZW-1:0]      fbase_r, fbase_nxt;
  logic [CW-1:0]       i_r, i_nxt;
  logic [CW-1:0]       j_r, j_nxt;
  logic [IDX_BITS-1:0] pidx_r, pidx_nxt;
  logic                err_r, err_nxt;
  logic                v1_r, v2_r;
  logic                issue;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_BITS-1:0]  opidx_r, opidx_nxt;
  logic [SUM_BITS-1:0]  osum_r, osum_nxt;
  logic                 olast_r, olast_nxt;
  logic                 oerr_r, oerr_nxt;

  logic [CW-1:0]        n_cfg;
  logic                 in_acc;
  logic [31:0]          addr_ext;
  logic [63:0]          val_ext;
  logic                 wr_ok;
  logic                 s_we, f_we;

  logic [DIM_BITS-1:0]  dims_w [NDIMS];
  logic [DIM_BITS-1:0]  cur_dim, cur_sdim;
  logic                 cur_bc;
  logic [PW-1:0]        iprod, sprod, fchk_p, schk_p;
  logic [SZW-1:0]       fchk, schk;
  logic                 size_err;
  logic                 wrap [NDIMS];
  logic [KW-1:0]        lvl;
  logic [SZW-1:0]       newoff;

  logic [ELEMENT_BITS-1:0] s_rdata, f_rdata;
  logic [AW-1:0]           s_raddr, f_raddr;
  logic [SZW-1:0]          s_sum, f_sum;
  logic signed [ACC_BITS-1:0] mac_acc;
  logic [63:0]             acc_ext;
  mac_ctl_t                mctl;

  function automatic logic [SZW-1:0] cap_f(input logic [PW-1:0] p);
    logic [SZW-1:0] r;
    if (p > PW'(STORE_DEPTH)) begin
      r = SZW'(STORE_DEPTH + 1);
    end else begin
      r = p[SZW-1:0];
    end
    return r;
  endfunction

  assign n_cfg = (32'(nc_r) > 32'(MAX_CATEGORIES)) ? CW'(MAX_CATEGORIES) : CW'(nc_r);

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign addr_ext = 32'(in_addr);
  assign val_ext  = 64'(in_value);
  assign wr_ok    = addr_ext < 32'(STORE_DEPTH);
  assign s_we     = in_acc && (in_req_type == REQ_SIGMA) && wr_ok;
  assign f_we     = in_acc && (in_req_type == REQ_FILTER) && wr_ok;

  // per-dimension sizes from the registers
  always_comb begin
    for (int k = 0; k < NDIMS; k++) begin
      dims_w[k] = dim_sel(KW'(k), fcc_r, dcc_r, ks_r, os_r);
    end
  end

  // sizing step: one dimension per cycle through the size multiplies
  assign cur_dim  = dims_w[k_r];
  assign cur_bc   = bm_r[dim_group(k_r)];
  assign cur_sdim = cur_bc ? DIM_BITS'(1) : cur_dim;
  assign iprod    = PW'(icap_r) * PW'(cur_dim);
  assign sprod    = PW'(sin_r) * PW'(cur_sdim);
  assign fchk_p   = PW'(n_r) * PW'(icap_r);
  assign schk_p   = PW'(n_r) * PW'(sin_r);
  assign fchk     = cap_f(fchk_p);
  assign schk     = cap_f(schk_p);
  assign size_err = (fchk > SZW'(STORE_DEPTH)) || (schk > SZW'(STORE_DEPTH));

  // counter chain: find the innermost level that does not wrap
  always_comb begin
    lvl = '0;
    for (int k = 0; k < NDIMS; k++) begin
      wrap[k] = ({1'b0, cnt_r[k]} + 9'd1) >= {1'b0, dims_w[k]};
      if (!wrap[k]) begin
        lvl = KW'(k);
      end
    end
    newoff = off_r[lvl] + sstride_r[lvl];
    for (int k = 0; k < NDIMS; k++) begin
      if (KW'(k) < lvl) begin
        cnt_nxt[k] = cnt_r[k];
        off_nxt[k] = off_r[k];
      end else if (KW'(k) == lvl) begin
        cnt_nxt[k] = cnt_r[k] + DIM_BITS'(1);
        off_nxt[k] = newoff;
      end else begin
        cnt_nxt[k] = '0;
        off_nxt[k] = newoff;
      end
    end
  end

  assign s_sum   = sbase_r + off_r[NDIMS-1];
  assign f_sum   = fbase_r + t_r;
  assign s_raddr = s_sum[AW-1:0];
  assign f_raddr = f_sum[AW-1:0];

  assign acc_ext = 64'(mac_acc);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    icap_nxt      = icap_r;
    sin_nxt       = sin_r;
    t_nxt         = t_r;
    sbase_nxt     = sbase_r;
    fbase_nxt     = fbase_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pidx_nxt      = pidx_r;
    err_nxt       = err_r;
    issue         = 1'b0;
    mctl          = '0;
    mctl.mul_en   = v1_r;
    mctl.acc_en   = v2_r;
    out_valid_nxt = out_valid_r && out_stall;
    opidx_nxt     = opidx_r;
    osum_nxt      = osum_r;
    olast_nxt     = olast_r;
    oerr_nxt      = oerr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_req_type == REQ_RUN) && (n_cfg != '0)) begin
          n_nxt     = n_cfg;
          k_nxt     = KW'(NDIMS - 1);
          icap_nxt  = SZW'(1);
          sin_nxt   = SZW'(1);
          state_nxt = ST_SIZE;
        end
      end
      ST_SIZE: begin
        icap_nxt = cap_f(iprod);
        sin_nxt  = cap_f(sprod);
        k_nxt    = k_r - KW'(1);
        if (k_r == '0) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        err_nxt   = size_err;
        i_nxt     = '0;
        j_nxt     = '0;
        sbase_nxt = '0;
        fbase_nxt = '0;
        pidx_nxt  = '0;
        state_nxt = size_err ? ST_EMIT : ST_PAIR_INIT;
      end
      ST_PAIR_INIT: begin
        mctl.clr  = 1'b1;
        t_nxt     = '0;
        state_nxt = (icap_r == '0) ? ST_DRAIN : ST_STREAM;
      end
      ST_STREAM: begin
        issue = 1'b1;
        t_nxt = t_r + SZW'(1);
        if ((t_r + SZW'(1)) == icap_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            opidx_nxt = '0;
            osum_nxt  = '0;
            olast_nxt = 1'b1;
            oerr_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            opidx_nxt = pidx_r;
            osum_nxt  = acc_ext[SUM_BITS-1:0];
            olast_nxt = (i_r == n_r - CW'(1)) && (j_r == n_r - CW'(1));
            oerr_nxt  = 1'b0;
            if (j_r == n_r - CW'(1)) begin
              if (i_r == n_r - CW'(1)) begin
                state_nxt = ST_IDLE;
              end else begin
                i_nxt     = i_r + CW'(1);
                j_nxt     = '0;
                sbase_nxt = sbase_r + sin_r;
                fbase_nxt = '0;
                pidx_nxt  = IDX_BITS'(i_r + CW'(1));
                state_nxt = ST_PAIR_INIT;
              end
            end else begin
              j_nxt     = j_r + CW'(1);
              fbase_nxt = fbase_r + icap_r;
              pidx_nxt  = pidx_r + IDX_BITS'(n_r);
              state_nxt = ST_PAIR_INIT;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      v1_r        <= issue;
      v2_r        <= v1_r;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    k_r     <= k_nxt;
    icap_r  <= icap_nxt;
    sin_r   <= sin_nxt;
    t_r     <= t_nxt;
    sbase_r <= sbase_nxt;
    fbase_r <= fbase_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    pidx_r  <= pidx_nxt;
    err_r   <= err_nxt;
    opidx_r <= opidx_nxt;
    osum_r  <= osum_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
    if (state_r == ST_SIZE) begin
      // broadcast groups walk with stride zero
      sstride_r[k_r] <= cur_bc ? '0 : sin_r;
    end
    for (int k = 0; k < NDIMS; k++) begin
      if (state_r == ST_PAIR_INIT) begin
        cnt_r[k] <= '0;
        off_r[k] <= '0;
      end else if (issue) begin
        cnt_r[k] <= cnt_nxt[k];
        off_r[k] <= off_nxt[k];
      end
    end
  end

  cptd_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW),
    .EB    (ELEMENT_BITS)
  ) u_sigma (
    .clk   (clk),
    .we    (s_we),
    .waddr (addr_ext[AW-1:0]),
    .wdata (val_ext[ELEMENT_BITS-1:0]),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  cptd_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW),
    .EB    (ELEMENT_BITS)
  ) u_filter (
    .clk   (clk),
    .we    (f_we),
    .waddr (addr_ext[AW-1:0]),
    .wdata (val_ext[ELEMENT_BITS-1:0]),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  cptd_mac #(
    .EB (ELEMENT_BITS),
    .AB (ACC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .a     (signed'(s_rdata)),
    .b     (signed'(f_rdata)),
    .acc   (mac_acc)
  );

  assign out_valid      = out_valid_r;
  assign out_pair_index = opidx_r;
  assign out_dot_sum    = signed'(osum_r);
  assign out_last       = olast_r;
  assign out_size_error = oerr_r;

`ifndef NO_ASSERTIONS
  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (!v1_r && !v2_r))
    else $error("result taken before the MAC pipeline drained");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_size_error) |-> (out_last && out_dot_sum == '0 && out_pair_index == '0))
    else $error("size error word malformed");

  a_stream_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STREAM) |-> (icap_r != '0 && t_r < icap_r))
    else $error("stream beyond inner size");

  a_pipe_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (state_r == ST_STREAM || state_r == ST_DRAIN))
    else $error("read in flight outside a pair");
`endif

endmodule
